/* hdl/mcte_pkg.sv */
package mcte_pkg;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned TEMPO_W = 24;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned REQ_W   = 2;

  // the divider's 34-bit dividend covers 60e6 * 256, its 41-bit divisor covers d * PPB
  localparam int unsigned NUM_W  = 34;
  localparam int unsigned DEN_W  = 41;
  localparam int unsigned DCNT_W = 6;
  localparam int unsigned PPB_W  = 7;

  localparam logic [REQ_W-1:0] REQ_CLOCK    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SILENCE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SONG_POS = 2'd2;

  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 24'hFFFFFF;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd30720;
  localparam logic [NUM_W-1:0]   TEMPO_NUM   = 34'd15360000000;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TIME_W-1:0] time_us;
  } in_req_t;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo_q8;
    logic [CNT_W-1:0]   pulse_count;
    logic               beat_boundary;
  } out_res_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DEL,
    OP_INS,
    OP_ROT
  } cell_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_TGO,
    ST_TDIV,
    ST_DEL,
    ST_INS,
    ST_SUM,
    ST_MEAN,
    ST_DONE
  } state_e;

endpackage

/* hdl/mcte_cell.sv */
module mcte_cell #(
  parameter int unsigned TAG_W   = 4,
  parameter int unsigned RST_TAG = 0,
  parameter bit          IS_LAST = 1'b0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mcte_pkg::cell_op_e               op_i,
  input  logic [mcte_pkg::TEMPO_W-1:0]     new_val_i,
  input  logic [TAG_W-1:0]                 new_tag_i,
  input  logic [TAG_W-1:0]                 del_tag_i,
  input  logic [mcte_pkg::TEMPO_W-1:0]     left_val_i,
  input  logic [TAG_W-1:0]                 left_tag_i,
  input  logic                             left_gt_i,
  input  logic [mcte_pkg::TEMPO_W-1:0]     right_val_i,
  input  logic [TAG_W-1:0]                 right_tag_i,
  input  logic                             found_i,
  output logic                             found_o,
  output logic                             gt_o,
  output logic [mcte_pkg::TEMPO_W-1:0]     val_o,
  output logic [TAG_W-1:0]                 tag_o
);
  import mcte_pkg::*;

  logic [TEMPO_W-1:0] val_q, val_d;
  logic [TAG_W-1:0]   tag_q, tag_d;

  // removed entry lies here or further left, so this cell pulls from the right
  assign found_o = found_i | (tag_q == del_tag_i);
  // the last cell is the slot vacated by the delete and counts as empty
  assign gt_o    = IS_LAST ? 1'b1 : (val_q > new_val_i);

  always_comb begin
    val_d = val_q;
    tag_d = tag_q;
    case (op_i)
      OP_DEL: begin
        if (found_o) begin
          val_d = right_val_i;
          tag_d = right_tag_i;
        end
      end
      OP_INS: begin
        if (gt_o) begin
          if (left_gt_i) begin
            val_d = left_val_i;
            tag_d = left_tag_i;
          end else begin
            val_d = new_val_i;
            tag_d = new_tag_i;
          end
        end
      end
      OP_ROT: begin
        val_d = right_val_i;
        tag_d = right_tag_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= TEMPO_RESET;
      tag_q <= TAG_W'(RST_TAG);
    end else begin
      val_q <= val_d;
      tag_q <= tag_d;
    end
  end

  assign val_o = val_q;
  assign tag_o = tag_q;

endmodule

/* hdl/mcte_div.sv */
module mcte_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mcte_pkg::NUM_W-1:0]   num_i,
  input  logic [mcte_pkg::DEN_W-1:0]   den_i,
  output logic                         done_o,
  output logic [mcte_pkg::NUM_W-1:0]   quo_o
);
  import mcte_pkg::*;

  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DCNT_W-1:0] cnt_q;
  logic              done_q;
  logic [DEN_W:0]    trial;
  logic              qbit;

  // one restoring step per cycle, quotient bits shift into the dividend register
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]} - {1'b0, den_q};
    qbit  = ~trial[DEN_W];
    rem_d = qbit ? trial[DEN_W-1:0] : {rem_q[DEN_W-2:0], num_q[NUM_W-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= DCNT_W'(NUM_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == DCNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

/* hdl/midi_clock_tempo_estimator_unit.sv */
// Tempo estimator for a MIDI clock stream. Each clock pulse request carries a
// microsecond timestamp; the interval to the previous timestamp becomes a tempo
// in BPM (unsigned Q16.8, saturating), which replaces the oldest entry of a
// WINDOW-deep history kept sorted in a chain of cells. The reported tempo is
// the mean of the MIDDLE centre entries of that sorted chain (all of them if
// MIDDLE exceeds WINDOW), together with a division pulse counter and a beat
// boundary flag. From acceptance to result, a 34-step restoring divider forms
// the interval-to-tempo quotient, the sum is taken by rotating the chain once
// round past its head cell, and the mean comes from the sum by one multiply
// with a reciprocal. The next request can be taken in the cycle after the
// result is registered.
// Silence ticks and song-position requests are handled at acceptance and give no result.
// A finished result sits in the output register while the next request is
// taken. No clearing pass is needed after reset.
module midi_clock_tempo_estimator_unit #(
  parameter int unsigned WINDOW          = 16,
  parameter int unsigned MIDDLE          = 8,
  parameter int unsigned PULSES_PER_BEAT = 24,
  parameter int unsigned DIVISION        = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mcte_pkg::in_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mcte_pkg::out_res_t out_data_o
);
  import mcte_pkg::*;

  localparam int unsigned TAG_W   = $clog2(WINDOW);
  localparam int unsigned MID_CNT = (MIDDLE < WINDOW) ? MIDDLE : WINDOW;
  localparam int unsigned LO_IDX  = (WINDOW - MID_CNT) / 2;
  localparam int unsigned HI_IDX  = (WINDOW + MID_CNT) / 2;
  localparam int unsigned SUM_W   = TEMPO_W + $clog2(MID_CNT + 1);
  localparam logic [PPB_W-1:0] PPB = PPB_W'(PULSES_PER_BEAT);
  localparam logic [CNT_W-1:0] DIV_CNT = CNT_W'(DIVISION);
  // floor(sum / MID_CNT) as (sum * ceil(2^MEAN_SH / MID_CNT)) >> MEAN_SH, exact for any sum
  localparam int unsigned MEAN_SH = SUM_W + $clog2(MID_CNT);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << MEAN_SH) + 64'(MID_CNT) - 64'd1) / 64'(MID_CNT);
  localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(RECIP_FULL);

  state_e             state_q, state_d;
  logic [TAG_W-1:0]   pos_q;
  logic [TIME_W-1:0]  last_q;
  logic [CNT_W-1:0]   divcnt_q;
  logic [CNT_W-1:0]   divcnt_inc;
  logic [TIME_W-1:0]  d_q;
  logic [DEN_W-1:0]   prod_q;
  logic               zero_q, big_q;
  logic [CNT_W-1:0]   res_cnt_q;
  logic               res_bnd_q;
  logic [TEMPO_W-1:0] tempo_q;
  logic [SUM_W-1:0]   sum_q;
  logic [SUM_W+RECIP_W-1:0] mean_prod;
  logic [TEMPO_W-1:0] mean_q;
  logic [TAG_W-1:0]   scnt_q;
  out_res_t           out_q;
  logic               out_valid_q;
  logic               in_acc;
  logic               out_free;

  cell_op_e           cell_op;
  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quo;

  logic [TEMPO_W-1:0] vals  [WINDOW];
  logic [TAG_W-1:0]   tags  [WINDOW];
  logic               gts   [WINDOW];
  logic               found [WINDOW+1];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign divcnt_inc = divcnt_q + 1'b1;
  assign mean_prod  = {{RECIP_W{1'b0}}, sum_q} * {{SUM_W{1'b0}}, MEAN_RECIP};

  // sorted history, head cell holds the smallest tempo
  assign found[0] = 1'b0;
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int unsigned LEFT  = (i == 0) ? 0 : i - 1;
    localparam int unsigned RIGHT = (i == WINDOW - 1) ? 0 : i + 1;
    mcte_cell #(
      .TAG_W  (TAG_W),
      .RST_TAG(i),
      .IS_LAST(i == WINDOW - 1)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .op_i       (cell_op),
      .new_val_i  (tempo_q),
      .new_tag_i  (pos_q),
      .del_tag_i  (pos_q),
      .left_val_i (vals[LEFT]),
      .left_tag_i (tags[LEFT]),
      .left_gt_i  ((i == 0) ? 1'b0 : gts[LEFT]),
      .right_val_i(vals[RIGHT]),
      .right_tag_i(tags[RIGHT]),
      .found_i    (found[i]),
      .found_o    (found[i+1]),
      .gt_o       (gts[i]),
      .val_o      (vals[i]),
      .tag_o      (tags[i])
    );
  end

  mcte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.req_type == REQ_CLOCK) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_TGO;
      ST_TGO:  state_d = ST_TDIV;
      ST_TDIV: begin
        if (div_done) begin
          state_d = ST_DEL;
        end
      end
      ST_DEL:  state_d = ST_INS;
      ST_INS:  state_d = ST_SUM;
      ST_SUM: begin
        if (scnt_q == TAG_W'(WINDOW - 1)) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cell_op   = OP_HOLD;
    div_start = 1'b0;
    div_num   = TEMPO_NUM;
    div_den   = prod_q;
    unique case (state_q)
      ST_TGO:  div_start = 1'b1;
      ST_DEL:  cell_op = OP_DEL;
      ST_INS:  cell_op = OP_INS;
      ST_SUM:  cell_op = OP_ROT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      last_q      <= '0;
      divcnt_q    <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        case (in_data_i.req_type)
          REQ_CLOCK: begin
            pos_q    <= (pos_q == TAG_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
            last_q   <= in_data_i.time_us;
            divcnt_q <= (divcnt_inc >= DIV_CNT) ? '0 : divcnt_inc;
          end
          REQ_SILENCE:  last_q   <= in_data_i.time_us;
          REQ_SONG_POS: divcnt_q <= DIV_CNT - 1'b1;
          default: ;
        endcase
      end
      if (state_q == ST_SUM) begin
        scnt_q <= (scnt_q == TAG_W'(WINDOW - 1)) ? '0 : scnt_q + 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      d_q       <= in_data_i.time_us - last_q;
      res_cnt_q <= divcnt_inc;
      res_bnd_q <= (divcnt_inc >= DIV_CNT);
    end
    if (state_q == ST_MUL) begin
      zero_q <= (d_q == '0);
      big_q  <= (d_q > TIME_W'(TEMPO_NUM));
      prod_q <= {{PPB_W{1'b0}}, d_q[NUM_W-1:0]} * {{NUM_W{1'b0}}, PPB};
    end
    if (state_q == ST_TDIV && div_done) begin
      if (zero_q) begin
        tempo_q <= TEMPO_MAX;
      end else if (big_q) begin
        tempo_q <= '0;
      end else if (div_quo > NUM_W'(TEMPO_MAX)) begin
        tempo_q <= TEMPO_MAX;
      end else begin
        tempo_q <= div_quo[TEMPO_W-1:0];
      end
    end
    if (state_q == ST_INS) begin
      sum_q <= '0;
    end else if (state_q == ST_SUM && scnt_q >= TAG_W'(LO_IDX)
                 && {1'b0, scnt_q} < (TAG_W+1)'(HI_IDX)) begin
      sum_q <= sum_q + SUM_W'(vals[0]);
    end
    if (state_q == ST_MEAN) begin
      mean_q <= mean_prod[MEAN_SH +: TEMPO_W];
    end
    if (state_q == ST_DONE && out_free) begin
      out_q.tempo_q8      <= mean_q;
      out_q.pulse_count   <= res_cnt_q;
      out_q.beat_boundary <= res_bnd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_bnd_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.beat_boundary |-> out_data_o.pulse_count == DIV_CNT)
    else $error("beat boundary without a full division");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pulse_count != '0 && out_data_o.pulse_count <= DIV_CNT)
    else $error("pulse count out of range");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_TDIV)
    else $error("divider finished outside a division step");

  a_sum_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MEAN |-> scnt_q == '0 && $past(state_q) == ST_SUM)
    else $error("chain rotation did not complete a full turn");

endmodule
